// File: hdl/hmbc_pkg.sv
// -----------------------------------------------------------------------------
// hmbc_pkg
// Shared types and constants of the handheld memory bus controller: memory
// map addresses, action and route codes, controller/datapath command and
// status bundles.
// -----------------------------------------------------------------------------
package hmbc_pkg;

   // Upper store geometry
   localparam int STORE_DEPTH = 32768;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // OAM DMA: 40 sprites of 4 bytes
   localparam int DMA_BYTES  = 40 * 4;
   localparam int COPY_CW    = $clog2(DMA_BYTES + 1);
   localparam int ELAPSED_W  = 10;
   localparam int DMA_CYCLES = 640;

   // Field widths
   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int ACTION_W = 2;
   localparam int MODE_W   = 2;
   localparam int ROUTE_W  = 2;

   // Memory map
   localparam logic [ADDR_W-1:0] VRAM_BASE     = 16'h8000;
   localparam logic [ADDR_W-1:0] VRAM_END      = 16'h9FFF;
   localparam logic [ADDR_W-1:0] OAM_BASE      = 16'hFE00;
   localparam logic [ADDR_W-1:0] OAM_END       = 16'hFE9F;
   localparam logic [ADDR_W-1:0] JOYP_ADDR     = 16'hFF00;
   localparam logic [ADDR_W-1:0] DIV_ADDR      = 16'hFF04;
   localparam logic [ADDR_W-1:0] LCDC_ADDR     = 16'hFF40;
   localparam logic [ADDR_W-1:0] LY_ADDR       = 16'hFF44;
   localparam logic [ADDR_W-1:0] DMA_ADDR      = 16'hFF46;
   localparam logic [ADDR_W-1:0] BOOT_OFF_ADDR = 16'hFF50;
   localparam logic [ADDR_W-1:0] HRAM_BASE     = 16'hFF80;
   localparam logic [ADDR_W-1:0] HRAM_END      = 16'hFFFE;
   localparam logic [ADDR_W-1:0] BOOT_LIMIT    = 16'h0100;

   localparam logic [STORE_AW-1:0] OAM_IDX = STORE_AW'(OAM_BASE);
   localparam logic [STORE_AW-1:0] LY_IDX  = STORE_AW'(LY_ADDR);

   // Data constants
   localparam logic [DATA_W-1:0] OPEN_BUS   = 8'hFF;
   localparam logic [DATA_W-1:0] JOYP_FORCE = 8'h0F;
   localparam int JOYP_DPAD_BIT = 4;   // 0x10 selects the d-pad when clear
   localparam int JOYP_BTN_BIT  = 5;   // 0x20 selects the action buttons
   localparam int LCD_ON_BIT    = 7;

   // PPU modes
   localparam logic [MODE_W-1:0] MODE_OAM_SCAN = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DRAWING  = 2'd3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2
   } action_type;

   typedef enum logic [ROUTE_W-1:0] {
      ROUTE_INTERNAL = 2'd0,
      ROUTE_CART_RD  = 2'd1,
      ROUTE_CART_WR  = 2'd2,
      ROUTE_BOOT_RD  = 2'd3
   } route_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic clear_step;
      logic copy_step;
      logic clear_ly;
      logic store;
      logic load_rd;
      logic load_rsp;
   } hmbc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic copy_last;
      logic mem_read;
      logic int_write;
      logic dma_copy;
      logic lcd_off;
   } hmbc_sts_type;

endpackage

// File: hdl/hmbc_if.sv
// -----------------------------------------------------------------------------
// hmbc_if
// Valid/ready channels of the memory bus controller: the request channel
// carrying bus transactions and the response channel carrying results.
// -----------------------------------------------------------------------------
interface hmbc_req_if import hmbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   addr;
   logic [DATA_W-1:0]   wr_data;
   logic [MODE_W-1:0]   video_mode;
   logic [DATA_W-1:0]   buttons;
   logic [DATA_W-1:0]   tick_cycles;

   modport source (
      output valid, action, addr, wr_data, video_mode, buttons, tick_cycles,
      input  ready
   );
   modport sink (
      input  valid, action, addr, wr_data, video_mode, buttons, tick_cycles,
      output ready
   );
endinterface

interface hmbc_rsp_if import hmbc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  rd_data;
   logic [ROUTE_W-1:0] route;
   logic [ADDR_W-1:0]  ext_addr;
   logic               ppu_reset;
   logic               timer_reset;
   logic               dma_active;
   logic               dma_unmodeled;

   modport source (
      output valid, rd_data, route, ext_addr, ppu_reset, timer_reset,
             dma_active, dma_unmodeled,
      input  ready
   );
   modport sink (
      input  valid, rd_data, route, ext_addr, ppu_reset, timer_reset,
             dma_active, dma_unmodeled,
      output ready
   );
endinterface

// File: hdl/hmbc_ram.sv
// -----------------------------------------------------------------------------
// hmbc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// -----------------------------------------------------------------------------
module hmbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/hmbc_dpath.sv
// -----------------------------------------------------------------------------
// hmbc_dpath
// Datapath of the memory bus controller: transaction capture, address
// decode, upper store with its clear and DMA copy counters, boot/DMA state
// and the response register.
// -----------------------------------------------------------------------------
module hmbc_dpath import hmbc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  hmbc_cmd_type        cmd,
   output hmbc_sts_type        sts,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [ADDR_W-1:0]   req_addr,
   input  logic [DATA_W-1:0]   req_wr_data,
   input  logic [MODE_W-1:0]   req_video_mode,
   input  logic [DATA_W-1:0]   req_buttons,
   input  logic [DATA_W-1:0]   req_tick_cycles,
   output logic [DATA_W-1:0]   rsp_rd_data,
   output logic [ROUTE_W-1:0]  rsp_route,
   output logic [ADDR_W-1:0]   rsp_ext_addr,
   output logic                rsp_ppu_reset,
   output logic                rsp_timer_reset,
   output logic                rsp_dma_active,
   output logic                rsp_dma_unmodeled
);

   // Captured transaction
   action_type          action_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [DATA_W-1:0]   data_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [DATA_W-1:0]   buttons_ff;
   logic [DATA_W-1:0]   tick_ff;

   // Block state
   logic                 boot_ff, boot_in;
   logic                 dma_run_ff, dma_run_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 lcd_on_ff;
   logic [STORE_AW-1:0]  clr_cnt_ff;
   logic [COPY_CW-1:0]   copy_cnt_ff;
   logic [DATA_W-1:0]    rd_ff;

   // Response register
   logic [DATA_W-1:0]  rsp_rd_ff, rsp_rd_in;
   route_type          rsp_route_ff, rsp_route_in;
   logic [ADDR_W-1:0]  rsp_ext_ff, rsp_ext_in;
   logic               rsp_ppu_ff, rsp_tmr_ff, rsp_dma_ff, rsp_unmod_ff;

   // Decode signals
   logic is_read, is_write, is_tick, is_upper;
   logic in_vram, in_oam, in_hram;
   logic lcd_blk, dma_blk, boot_hit;
   logic int_write, lcd_off, dma_start, dma_copy, div_write, boot_off;
   logic [DATA_W-1:0]    pad;
   logic [ELAPSED_W-1:0] elapsed_sum;

   // RAM port
   logic                ram_we;
   logic [STORE_AW-1:0] ram_waddr, ram_raddr, src_base;
   logic [DATA_W-1:0]   ram_wdata, ram_rdata;

   // Capture transaction on accept
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= action_type'(req_action);
         addr_ff    <= req_addr;
         data_ff    <= req_wr_data;
         mode_ff    <= req_video_mode;
         buttons_ff <= req_buttons;
         tick_ff    <= req_tick_cycles;
      end
      if (cmd.load_rd) begin
         rd_ff <= ram_rdata;
      end
   end

   // Decode the held transaction
   always_comb begin
      is_read   = (action_ff == ACT_READ);
      is_write  = (action_ff == ACT_WRITE);
      is_tick   = (action_ff == ACT_TICK);
      is_upper  = addr_ff[ADDR_W-1];
      in_vram   = (addr_ff >= VRAM_BASE) && (addr_ff <= VRAM_END);
      in_oam    = (addr_ff >= OAM_BASE) && (addr_ff <= OAM_END);
      in_hram   = (addr_ff >= HRAM_BASE) && (addr_ff <= HRAM_END);
      lcd_blk   = lcd_on_ff &&
                  ((in_vram && (mode_ff == MODE_DRAWING)) ||
                   (in_oam && ((mode_ff == MODE_OAM_SCAN) || (mode_ff == MODE_DRAWING))));
      dma_blk   = dma_run_ff && !in_hram;
      boot_hit  = boot_ff && (addr_ff < BOOT_LIMIT);
      int_write = is_write && is_upper && !lcd_blk && (addr_ff != LY_ADDR);
      lcd_off   = int_write && (addr_ff == LCDC_ADDR) && !data_ff[LCD_ON_BIT];
      dma_start = int_write && (addr_ff == DMA_ADDR);
      dma_copy  = dma_start && data_ff[DATA_W-1];
      div_write = int_write && (addr_ff == DIV_ADDR);
      boot_off  = int_write && (addr_ff == BOOT_OFF_ADDR);
   end

   // Compose joypad byte from the selected button groups
   always_comb begin
      pad = rd_ff | JOYP_FORCE;
      if (!pad[JOYP_DPAD_BIT]) begin
         pad[3:0] = pad[3:0] & ~buttons_ff[3:0];
      end
      if (!pad[JOYP_BTN_BIT]) begin
         pad[3:0] = pad[3:0] & ~buttons_ff[7:4];
      end
   end

   // Result fields
   always_comb begin
      rsp_rd_in    = '0;
      rsp_route_in = ROUTE_INTERNAL;
      rsp_ext_in   = '0;
      if (is_read) begin
         if (dma_blk || lcd_blk) begin
            rsp_rd_in = OPEN_BUS;
         end else if (boot_hit) begin
            rsp_route_in = ROUTE_BOOT_RD;
            rsp_ext_in   = addr_ff;
         end else if (addr_ff == JOYP_ADDR) begin
            rsp_rd_in = pad;
         end else if (!is_upper) begin
            rsp_route_in = ROUTE_CART_RD;
            rsp_ext_in   = addr_ff;
         end else begin
            rsp_rd_in = rd_ff;
         end
      end else if (is_write && !is_upper) begin
         rsp_route_in = ROUTE_CART_WR;
         rsp_ext_in   = addr_ff;
      end
   end

   // Next boot and DMA window state
   always_comb begin
      elapsed_sum = elapsed_ff + ELAPSED_W'(tick_ff);
      boot_in     = boot_ff && !boot_off;
      dma_run_in  = dma_run_ff;
      elapsed_in  = elapsed_ff;
      if (dma_start) begin
         dma_run_in = 1'b1;
         elapsed_in = '0;
      end else if (is_tick && dma_run_ff) begin
         elapsed_in = elapsed_sum;
         dma_run_in = (elapsed_sum < ELAPSED_W'(DMA_CYCLES));
      end
   end

   // Commit state and response together
   always_ff @(posedge clock) begin
      if (reset) begin
         boot_ff    <= 1'b1;
         dma_run_ff <= 1'b0;
         elapsed_ff <= '0;
      end else if (cmd.load_rsp) begin
         boot_ff    <= boot_in;
         dma_run_ff <= dma_run_in;
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_rd_ff    <= rsp_rd_in;
         rsp_route_ff <= rsp_route_in;
         rsp_ext_ff   <= rsp_ext_in;
         rsp_ppu_ff   <= lcd_off;
         rsp_tmr_ff   <= div_write;
         rsp_dma_ff   <= dma_run_in;
         rsp_unmod_ff <= dma_start && !data_ff[DATA_W-1];
      end
   end

   // Track LCD enable alongside the stored LCDC byte
   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_on_ff <= 1'b0;
      end else if (cmd.store && (addr_ff == LCDC_ADDR)) begin
         lcd_on_ff <= data_ff[LCD_ON_BIT];
      end
   end

   // Advance clear sweep and DMA copy counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         copy_cnt_ff <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.copy_step) begin
            copy_cnt_ff <= sts.copy_last ? '0 : copy_cnt_ff + 1'b1;
         end
      end
   end

   // Steer the RAM ports
   always_comb begin
      src_base  = STORE_AW'({data_ff, 8'h00});
      ram_we    = 1'b0;
      ram_waddr = addr_ff[STORE_AW-1:0];
      ram_wdata = data_ff;
      ram_raddr = addr_ff[STORE_AW-1:0];
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else if (cmd.copy_step) begin
         ram_raddr = src_base + STORE_AW'(copy_cnt_ff);
         ram_we    = (copy_cnt_ff != '0);
         ram_waddr = OAM_IDX + STORE_AW'(COPY_CW'(copy_cnt_ff - 1'b1));
         ram_wdata = ram_rdata;
      end else if (cmd.clear_ly) begin
         ram_we    = 1'b1;
         ram_waddr = LY_IDX;
         ram_wdata = '0;
      end else if (cmd.store) begin
         ram_we    = 1'b1;
         ram_wdata = div_write ? '0 : data_ff;
      end
   end

   hmbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Status to controller
   always_comb begin
      sts.clear_last = (clr_cnt_ff == STORE_AW'(STORE_DEPTH - 1));
      sts.copy_last  = (copy_cnt_ff == COPY_CW'(DMA_BYTES));
      sts.mem_read   = is_read && !dma_blk && !lcd_blk && is_upper;
      sts.int_write  = int_write;
      sts.dma_copy   = dma_copy;
      sts.lcd_off    = lcd_off;
   end

   assign rsp_rd_data       = rsp_rd_ff;
   assign rsp_route         = rsp_route_ff;
   assign rsp_ext_addr      = rsp_ext_ff;
   assign rsp_ppu_reset     = rsp_ppu_ff;
   assign rsp_timer_reset   = rsp_tmr_ff;
   assign rsp_dma_active    = rsp_dma_ff;
   assign rsp_dma_unmodeled = rsp_unmod_ff;

endmodule

// File: hdl/hmbc_ctrl.sv
// -----------------------------------------------------------------------------
// hmbc_ctrl
// Controller of the memory bus controller: sequences the clear sweep,
// transaction decode, memory read, DMA copy, stores and the response hand-off.
// -----------------------------------------------------------------------------
module hmbc_ctrl import hmbc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output hmbc_cmd_type cmd,
   input  hmbc_sts_type sts
);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_DECODE = 8'b0000_0100,
      ST_READ   = 8'b0000_1000,
      ST_COPY   = 8'b0001_0000,
      ST_CLRLY  = 8'b0010_0000,
      ST_STORE  = 8'b0100_0000,
      ST_REPLY  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.mem_read) begin
               state_in = ST_READ;
            end else if (sts.dma_copy) begin
               state_in = ST_COPY;
            end else if (sts.lcd_off) begin
               state_in = ST_CLRLY;
            end else if (sts.int_write) begin
               state_in = ST_STORE;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_READ: begin
            cmd.load_rd = 1'b1;
            state_in    = ST_REPLY;
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (sts.copy_last) begin
               state_in = ST_STORE;
            end
         end
         ST_CLRLY: begin
            cmd.clear_ly = 1'b1;
            state_in     = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = ST_REPLY;
         end
         ST_REPLY: begin
            cmd.load_rsp = slot_free;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Hold response valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/handheld_memory_bus_controller_unit.sv
// -----------------------------------------------------------------------------
// handheld_memory_bus_controller_unit
// Memory bus controller of an 8-bit handheld holding the upper 32 KiB.
// -----------------------------------------------------------------------------
// After reset the block sweeps its 32768-byte store to zero, one byte per
// cycle, and takes no transaction until the sweep is done. A transaction then
// passes decode and reply when it needs no store access (cartridge or boot ROM
// routing, blocked reads, ticks), adds a read or store step for an internal
// read or write, clears LY before the store for a write turning the LCD off,
// and copies 160 bytes before the store for a DMA start from an upper page,
// one byte per cycle through the single read and single write port of the
// store. A finished response sits in an output register, so the next
// transaction is accepted while the previous response waits to be taken.
// -----------------------------------------------------------------------------
module handheld_memory_bus_controller_unit import hmbc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hmbc_req_if.sink   req_bus,
   hmbc_rsp_if.source rsp_bus
);

   hmbc_cmd_type cmd;
   hmbc_sts_type sts;

   hmbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   hmbc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_bus.action),
      .req_addr          (req_bus.addr),
      .req_wr_data       (req_bus.wr_data),
      .req_video_mode    (req_bus.video_mode),
      .req_buttons       (req_bus.buttons),
      .req_tick_cycles   (req_bus.tick_cycles),
      .rsp_rd_data       (rsp_bus.rd_data),
      .rsp_route         (rsp_bus.route),
      .rsp_ext_addr      (rsp_bus.ext_addr),
      .rsp_ppu_reset     (rsp_bus.ppu_reset),
      .rsp_timer_reset   (rsp_bus.timer_reset),
      .rsp_dma_active    (rsp_bus.dma_active),
      .rsp_dma_unmodeled (rsp_bus.dma_unmodeled)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the handheld memory bus controller. Bus transactions
// (reads, writes, ticks) go in on the request channel while a local memory-map
// model computes each response; the response channel is compared field by
// field. Directed checks cover routing, special registers, LCD blocking, OAM
// DMA and boot-ROM unmapping, mixed with weighted random traffic with idle
// gaps on both sides and one long response hold-off.
// -----------------------------------------------------------------------------
module testbench;
   import hmbc_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   wr_data;
      logic [MODE_W-1:0]   video_mode;
      logic [DATA_W-1:0]   buttons;
      logic [DATA_W-1:0]   tick_cycles;
   } bus_op_type;

   typedef struct packed {
      logic [DATA_W-1:0]  rd_data;
      logic [ROUTE_W-1:0] route;
      logic [ADDR_W-1:0]  ext_addr;
      logic               ppu_reset;
      logic               timer_reset;
      logic               dma_active;
      logic               dma_unmodeled;
   } bus_reply_type;

   logic clock;
   logic reset;

   hmbc_req_if req_bus ();
   hmbc_rsp_if rsp_bus ();

   handheld_memory_bus_controller_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Memory-map model state
   logic [DATA_W-1:0]    mem_image [STORE_DEPTH];
   logic                 boot_mapped;
   logic                 dma_window;
   logic [ELAPSED_W-1:0] dma_cycles_seen;

   bus_reply_type replies_due [$];

   int  fail_count;
   int  ops_sent;
   int  results_checked;
   int  dma_starts;
   int  blocked_hits;
   int  hold_cycles;
   bit  idle_enable;
   bit  stall_enable;

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit: store sweep plus worst-case DMA-heavy traffic, several times over
   initial begin
      #4000000;
      $display("Timeout with %0d responses outstanding", replies_due.size());
      $display("== FAIL ==");
      $finish;
   end

   // VRAM/OAM lockout while the LCD is on
   function automatic bit access_locked(input logic [ADDR_W-1:0] a, input logic [MODE_W-1:0] m);
      if (!mem_image[LCDC_ADDR[STORE_AW-1:0]][LCD_ON_BIT])
         return 1'b0;
      if (a >= VRAM_BASE && a <= VRAM_END && m == MODE_DRAWING)
         return 1'b1;
      if (a >= OAM_BASE && a <= OAM_END && (m == MODE_OAM_SCAN || m == MODE_DRAWING))
         return 1'b1;
      return 1'b0;
   endfunction

   // Apply one transaction to the memory map and return its response
   function automatic bus_reply_type decode_bus_op(input bus_op_type op);
      bus_reply_type     r;
      logic [DATA_W-1:0] joyp;
      logic [ADDR_W-1:0] src;
      logic [DATA_W-1:0] page_copy [DMA_BYTES];
      r = '0;
      case (op.action)
         ACT_READ: begin
            if (dma_window && (op.addr < HRAM_BASE || op.addr > HRAM_END)) begin
               r.rd_data = OPEN_BUS;
            end else if (access_locked(op.addr, op.video_mode)) begin
               r.rd_data = OPEN_BUS;
               blocked_hits++;
            end else if (boot_mapped && op.addr < BOOT_LIMIT) begin
               r.route    = ROUTE_BOOT_RD;
               r.ext_addr = op.addr;
            end else if (op.addr == JOYP_ADDR) begin
               joyp = mem_image[JOYP_ADDR[STORE_AW-1:0]] | JOYP_FORCE;
               if (!joyp[JOYP_DPAD_BIT])
                  joyp = joyp & ~{4'h0, op.buttons[3:0]};
               if (!joyp[JOYP_BTN_BIT])
                  joyp = joyp & ~{4'h0, op.buttons[7:4]};
               r.rd_data = joyp;
            end else if (op.addr < VRAM_BASE) begin
               r.route    = ROUTE_CART_RD;
               r.ext_addr = op.addr;
            end else begin
               r.rd_data = mem_image[op.addr[STORE_AW-1:0]];
            end
         end
         ACT_WRITE: begin
            if (op.addr < VRAM_BASE) begin
               r.route    = ROUTE_CART_WR;
               r.ext_addr = op.addr;
            end else if (access_locked(op.addr, op.video_mode)) begin
               blocked_hits++;
            end else if (op.addr != LY_ADDR) begin
               if (op.addr == LCDC_ADDR && !op.wr_data[LCD_ON_BIT]) begin
                  mem_image[LY_IDX] = '0;
                  r.ppu_reset = 1'b1;
               end
               if (op.addr == BOOT_OFF_ADDR)
                  boot_mapped = 1'b0;
               if (op.addr == DMA_ADDR) begin
                  src = {op.wr_data, 8'h00};
                  if (src < VRAM_BASE) begin
                     r.dma_unmodeled = 1'b1;
                  end else begin
                     // copy through a buffer so overlapping pages behave
                     for (int i = 0; i < DMA_BYTES; i++)
                        page_copy[i] = mem_image[STORE_AW'(src + i)];
                     for (int i = 0; i < DMA_BYTES; i++)
                        mem_image[STORE_AW'(OAM_IDX + i)] = page_copy[i];
                  end
                  dma_window      = 1'b1;
                  dma_cycles_seen = '0;
                  dma_starts++;
               end
               if (op.addr == DIV_ADDR) begin
                  mem_image[DIV_ADDR[STORE_AW-1:0]] = '0;
                  r.timer_reset = 1'b1;
               end else begin
                  mem_image[op.addr[STORE_AW-1:0]] = op.wr_data;
               end
            end
         end
         ACT_TICK: begin
            if (dma_window) begin
               dma_cycles_seen = ELAPSED_W'(dma_cycles_seen + op.tick_cycles);
               if (dma_cycles_seen >= DMA_CYCLES)
                  dma_window = 1'b0;
            end
         end
         default: ;
      endcase
      r.dma_active = dma_window;
      return r;
   endfunction

   // Offer one transaction, wait for acceptance, then queue its expected response
   task automatic send_item(input bus_op_type op);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= op.action;
      req_bus.addr        <= op.addr;
      req_bus.wr_data     <= op.wr_data;
      req_bus.video_mode  <= op.video_mode;
      req_bus.buttons     <= op.buttons;
      req_bus.tick_cycles <= op.tick_cycles;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      replies_due.push_back(decode_bus_op(op));
      ops_sent++;
   endtask

   task automatic issue(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] a,
                        input logic [DATA_W-1:0] d, input logic [MODE_W-1:0] m,
                        input logic [DATA_W-1:0] btn, input logic [DATA_W-1:0] cyc);
      bus_op_type op;
      op = '{action: act, addr: a, wr_data: d, video_mode: m, buttons: btn, tick_cycles: cyc};
      send_item(op);
   endtask

   // Weighted address picker: small windows so reads find earlier writes
   function automatic logic [ADDR_W-1:0] pick_addr(input bit boot_off_ok);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 5)
         return ADDR_W'($urandom_range(0, 'hFF));
      else if (sel < 13)
         return ADDR_W'($urandom_range('h100, 'h7FFF));
      else if (sel < 23)
         return VRAM_BASE + ADDR_W'($urandom_range(0, 63));
      else if (sel < 27)
         return ADDR_W'($urandom_range('h8000, 'hFDFF));
      else if (sel < 40)
         return OAM_BASE + ADDR_W'($urandom_range(0, 'hBF));
      else if (sel < 45)
         return ADDR_W'($urandom_range('hFEA0, 'hFF7F));
      else if (sel < 75) begin
         case ($urandom_range(0, 6))
            0: return JOYP_ADDR;
            1: return DIV_ADDR;
            2: return LCDC_ADDR;
            3: return LY_ADDR;
            4: return DMA_ADDR;
            5: return boot_off_ok ? BOOT_OFF_ADDR : LCDC_ADDR;
            default: return ADDR_W'($urandom_range('hFF00, 'hFF7F));
         endcase
      end
      return ADDR_W'($urandom_range('hFF7F, 'hFFFF));
   endfunction

   function automatic bus_op_type random_op(input bit boot_off_ok);
      bus_op_type op;
      int         sel;
      op.addr        = pick_addr(boot_off_ok);
      op.wr_data     = DATA_W'($urandom_range(0, 255));
      op.video_mode  = MODE_W'($urandom_range(0, 3));
      op.buttons     = DATA_W'($urandom_range(0, 255));
      op.tick_cycles = DATA_W'($urandom_range(0, 255));
      sel = $urandom_range(0, 99);
      if (sel < 42)
         op.action = ACT_READ;
      else if (sel < 84)
         op.action = ACT_WRITE;
      else if (sel < 99)
         op.action = ACT_TICK;
      else
         op.action = ACT_UNUSED;
      // favor DMA sources that actually copy
      if (op.action == ACT_WRITE && op.addr == DMA_ADDR && $urandom_range(0, 3) != 0)
         op.wr_data[7] = 1'b1;
      return op;
   endfunction

   // -------------------------------------------------------------------------
   // Response side: random stalls, optional long hold-off, result checking
   // -------------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                                input logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_reply();
      bus_reply_type want;
      if (replies_due.size() == 0) begin
         $display("%0t ns: response with nothing outstanding, expected none, actual %0h/%0d/%0h",
                  $time, rsp_bus.rd_data, rsp_bus.route, rsp_bus.ext_addr);
         fail_count++;
      end else begin
         want = replies_due.pop_front();
         results_checked++;
         compare_field("rd_data", ADDR_W'(want.rd_data), ADDR_W'(rsp_bus.rd_data));
         compare_field("route", ADDR_W'(want.route), ADDR_W'(rsp_bus.route));
         compare_field("ext_addr", want.ext_addr, rsp_bus.ext_addr);
         compare_field("ppu_reset", ADDR_W'(want.ppu_reset), ADDR_W'(rsp_bus.ppu_reset));
         compare_field("timer_reset", ADDR_W'(want.timer_reset),
                       ADDR_W'(rsp_bus.timer_reset));
         compare_field("dma_active", ADDR_W'(want.dma_active), ADDR_W'(rsp_bus.dma_active));
         compare_field("dma_unmodeled", ADDR_W'(want.dma_unmodeled),
                       ADDR_W'(rsp_bus.dma_unmodeled));
      end
   endtask

   initial begin : rsp_drain
      int burst;
      burst = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            check_reply();
         // hold off, stall in short bursts, or take the response
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_enable && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_routing();
      issue(ACT_READ, 16'h0000, 8'h00, 2'd0, 8'h00, 8'h00);
      issue(ACT_READ, 16'h00FF, 8'h00, 2'd1, 8'h00, 8'h00);
      issue(ACT_READ, 16'h0100, 8'h00, 2'd2, 8'h00, 8'h00);
      issue(ACT_WRITE, 16'h7FFF, 8'hFF, 2'd3, 8'hFF, 8'hFF);
   endtask

   task automatic test_internal_regs();
      issue(ACT_WRITE, 16'h8000, 8'hA5, 2'd3, 8'h00, 8'h00);
      issue(ACT_READ, 16'h8000, 8'h00, 2'd3, 8'h00, 8'h00);
      issue(ACT_WRITE, 16'hFFFF, 8'h5A, 2'd0, 8'h00, 8'h00);
      issue(ACT_WRITE, LY_ADDR, 8'h33, 2'd0, 8'h00, 8'h00);
      issue(ACT_READ, LY_ADDR, 8'h00, 2'd0, 8'h00, 8'h00);
      issue(ACT_WRITE, DIV_ADDR, 8'h77, 2'd0, 8'h00, 8'h00);
      // joypad with d-pad selected, then with action buttons selected
      issue(ACT_WRITE, JOYP_ADDR, 8'h20, 2'd0, 8'h00, 8'h00);
      issue(ACT_READ, JOYP_ADDR, 8'h00, 2'd0, 8'h5A, 8'h00);
      issue(ACT_WRITE, JOYP_ADDR, 8'h10, 2'd0, 8'h00, 8'h00);
      issue(ACT_READ, JOYP_ADDR, 8'h00, 2'd0, 8'hA5, 8'h00);
   endtask

   task automatic test_lcd_blocking();
      issue(ACT_WRITE, LCDC_ADDR, 8'h91, 2'd0, 8'h00, 8'h00);
      issue(ACT_WRITE, VRAM_END, 8'h3C, MODE_DRAWING, 8'h00, 8'h00);
      issue(ACT_READ, VRAM_END, 8'h00, MODE_DRAWING, 8'h00, 8'h00);
      issue(ACT_READ, OAM_END, 8'h00, MODE_OAM_SCAN, 8'h00, 8'h00);
      issue(ACT_WRITE, LCDC_ADDR, 8'h00, 2'd0, 8'h00, 8'h00);
   endtask

   task automatic test_oam_dma();
      issue(ACT_WRITE, DMA_ADDR, 8'h80, 2'd0, 8'h00, 8'h00);
      issue(ACT_READ, OAM_BASE, 8'h00, 2'd0, 8'h00, 8'h00);
      issue(ACT_READ, HRAM_BASE, 8'h00, 2'd0, 8'h00, 8'h00);
      // low source page: restarts the window but copies nothing
      issue(ACT_WRITE, DMA_ADDR, 8'h12, 2'd0, 8'h00, 8'h00);
      issue(ACT_TICK, 16'h0000, 8'h00, 2'd0, 8'h00, 8'h00);
      issue(ACT_TICK, 16'h0000, 8'h00, 2'd0, 8'h00, 8'hFF);
      issue(ACT_TICK, 16'hFFFF, 8'hFF, 2'd3, 8'hFF, 8'hFF);
      issue(ACT_TICK, 16'h0000, 8'h00, 2'd0, 8'h00, 8'hFF);
      issue(ACT_READ, OAM_BASE, 8'h00, 2'd0, 8'h00, 8'h00);
      issue(ACT_UNUSED, 16'hFF46, 8'h80, 2'd0, 8'hFF, 8'hFF);
   endtask

   task automatic test_boot_disable();
      issue(ACT_WRITE, BOOT_OFF_ADDR, 8'h01, 2'd0, 8'h00, 8'h00);
      issue(ACT_READ, 16'h0000, 8'h00, 2'd0, 8'h00, 8'h00);
   endtask

   task automatic test_random_traffic(input int count, input bit boot_off_ok);
      for (int n = 0; n < count; n++)
         send_item(random_op(boot_off_ok));
   endtask

   // Hold the response side long enough for the request side to back up
   task automatic test_backpressure();
      hold_cycles = 200;
      for (int n = 0; n < 16; n++)
         send_item(random_op(1'b1));
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      fail_count      = 0;
      ops_sent        = 0;
      results_checked = 0;
      dma_starts      = 0;
      blocked_hits    = 0;
      hold_cycles     = 0;
      idle_enable     = 1'b1;
      stall_enable    = 1'b1;
      boot_mapped     = 1'b1;
      dma_window      = 1'b0;
      dma_cycles_seen = '0;
      foreach (mem_image[i])
         mem_image[i] = '0;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_READ;
      req_bus.addr        = '0;
      req_bus.wr_data     = '0;
      req_bus.video_mode  = '0;
      req_bus.buttons     = '0;
      req_bus.tick_cycles = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_routing();
      test_internal_regs();
      test_lcd_blocking();
      test_oam_dma();
      test_random_traffic(400, 1'b0);
      test_boot_disable();
      test_backpressure();
      test_random_traffic(450, 1'b1);
      idle_enable  = 1'b0;
      stall_enable = 1'b0;
      test_random_traffic(150, 1'b1);

      // drop valid, drain outstanding responses, then allow a DMA-length tail
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d bus transactions, checked %0d responses, %0d OAM DMA starts.",
               ops_sent, results_checked, dma_starts);
      $display("Blocked VRAM/OAM accesses: %0d; routing, joypad, LCD-off, DIV, LY, boot-off,",
               blocked_hits);
      $display("DMA lockout and response back-pressure exercised.");
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: sim.f
hdl/hmbc_pkg.sv
hdl/hmbc_if.sv
hdl/hmbc_ram.sv
hdl/hmbc_dpath.sv
hdl/hmbc_ctrl.sv
hdl/handheld_memory_bus_controller_unit.sv
tb/testbench.sv
